[rtl/core/utfh_pkg.sv]
// Package for the UTF-8 codepoint histogram: field widths, command and
// register codes, reset values and the decoder-to-core event type.
// No dependencies.
`default_nettype none

package utfh_pkg;

   localparam int CP_WIDTH            = 21;
   localparam int BYTE_WIDTH          = 8;
   localparam int INDEX_WIDTH         = 14;
   localparam int RSP_COUNT_WIDTH     = 32;
   localparam int CSR_INDEX_WIDTH     = 2;
   localparam int BIN_COUNT_DEFAULT   = 16384;
   localparam int COUNT_WIDTH_DEFAULT = 32;

   localparam logic CMD_FEED = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RANGE_FIRST = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RANGE_LAST  = 2'd1;

   localparam logic [CP_WIDTH-1:0] RANGE_FIRST_RESET = 21'h00AC00;
   localparam logic [CP_WIDTH-1:0] RANGE_LAST_RESET  = 21'h00D7A3;

   typedef struct packed {
      logic                valid;
      logic [CP_WIDTH-1:0] codepoint;
   } cp_evt_type;

endpackage

`default_nettype wire

[rtl/core/utfh_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// A read and a write to the same address in one cycle return the old data.
// No dependencies.
`default_nettype none

module utfh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16384
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/core/utfh_decoder.sv]
// UTF-8 byte decoder: rebuilds codepoints one byte per cycle and emits a
// registered event when a codepoint completes. Depends on utfh_pkg.
`default_nettype none

module utfh_decoder (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             feed_en,
   input  wire logic [utfh_pkg::BYTE_WIDTH-1:0]  text_byte,
   output utfh_pkg::cp_evt_type                  cp_evt
);

   import utfh_pkg::*;

   logic [1:0]          expect_ff, expect_in;
   logic [CP_WIDTH-1:0] partial_ff, partial_in;
   cp_evt_type          evt_ff, evt_in;

   always_comb begin
      expect_in  = expect_ff;
      partial_in = partial_ff;
      evt_in     = '0;
      if (feed_en) begin
         if (expect_ff == 2'd0) begin
            if (text_byte[7] == 1'b0) begin
               evt_in.valid     = 1'b1;
               evt_in.codepoint = CP_WIDTH'(text_byte);
            end else if (text_byte[7:5] == 3'b110) begin
               partial_in = CP_WIDTH'(text_byte[4:0]);
               expect_in  = 2'd1;
            end else if (text_byte[7:4] == 4'b1110) begin
               partial_in = CP_WIDTH'(text_byte[3:0]);
               expect_in  = 2'd2;
            end else begin
               partial_in = CP_WIDTH'(text_byte[2:0]);
               expect_in  = 2'd3;
            end
         end else begin
            partial_in = {partial_ff[CP_WIDTH-7:0], text_byte[5:0]};
            expect_in  = expect_ff - 2'd1;
            if (expect_ff == 2'd1) begin
               evt_in.valid     = 1'b1;
               evt_in.codepoint = partial_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_ff  <= 2'd0;
         partial_ff <= '0;
         evt_ff     <= '0;
      end else begin
         expect_ff  <= expect_in;
         partial_ff <= partial_in;
         evt_ff     <= evt_in;
      end
   end

   assign cp_evt = evt_ff;

endmodule

`default_nettype wire

[rtl/core/utf8_codepoint_histogram.sv]
// Top level of the UTF-8 codepoint histogram: decoder, range check and a
// count memory updated by read-modify-write with forwarding.
// Depends on utfh_pkg, utfh_decoder and utfh_ram.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | req_cmd, req_text_byte, req_bin_index
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_bin_count, rsp_bin_codepoint
//   csr     | in        | csr_valid/csr_ready  | csr_index, csr_wdata
//
// Text bytes are taken one per cycle while req_stall is low; a completed codepoint
// updates its bin through the decoder's event register and the s2 stage, with
// forwarding between back-to-back updates. A read transaction's result passes
// through s1 and s2 into the output register; the next read waits until that
// result has left the output register, and rsp_stall holds it there longer.
// After reset a clearing pass writes zero to every bin, one per cycle, with
// req_stall held high; csr writes are taken throughout.
`default_nettype none

module utf8_codepoint_histogram #(
   parameter int BIN_COUNT   = utfh_pkg::BIN_COUNT_DEFAULT,
   parameter int COUNT_WIDTH = utfh_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic                                  req_cmd,
   input  wire logic [utfh_pkg::BYTE_WIDTH-1:0]       req_text_byte,
   input  wire logic [utfh_pkg::INDEX_WIDTH-1:0]      req_bin_index,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic      [utfh_pkg::RSP_COUNT_WIDTH-1:0]  rsp_bin_count,
   output logic      [utfh_pkg::CP_WIDTH-1:0]         rsp_bin_codepoint,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [utfh_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [utfh_pkg::CP_WIDTH-1:0]         csr_wdata
);

   import utfh_pkg::*;

   localparam int ADDR_W = $clog2(BIN_COUNT);
   localparam logic [CP_WIDTH:0]   BIN_LIMIT = (CP_WIDTH+1)'(BIN_COUNT);
   localparam logic [ADDR_W-1:0]   LAST_ADDR = ADDR_W'(BIN_COUNT - 1);

   logic                   req_take;
   logic                   feed_en;
   cp_evt_type             cp_evt;

   logic [CP_WIDTH-1:0]    first_ff, last_ff;
   logic                   clear_ff;
   logic [ADDR_W-1:0]      clear_addr_ff;

   logic                   s1_rd_ff;
   logic [INDEX_WIDTH-1:0] s1_idx_ff;

   logic                   s2_inc_ff, s2_inc_in;
   logic                   s2_rd_ff;
   logic                   s2_oob_ff;
   logic [ADDR_W-1:0]      s2_addr_ff;
   logic [CP_WIDTH-1:0]    s2_cp_ff;

   logic                   fwd_hit_ff;
   logic [COUNT_WIDTH-1:0] fwd_data_ff;

   logic                   rsp_valid_ff;
   logic [RSP_COUNT_WIDTH-1:0] rsp_count_ff;
   logic [CP_WIDTH-1:0]    rsp_cp_ff;

   logic [CP_WIDTH-1:0]    bin_diff;
   logic [ADDR_W-1:0]      rd_addr;
   logic [COUNT_WIDTH-1:0] ram_rd_data;
   logic [COUNT_WIDTH-1:0] cur_count;
   logic [COUNT_WIDTH-1:0] new_count;
   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;
   logic [COUNT_WIDTH-1:0] wr_data;

   assign req_stall = clear_ff ||
                      (req_cmd == CMD_READ && (s1_rd_ff || s2_rd_ff || rsp_valid_ff));
   assign req_take  = req_valid && !req_stall;
   assign feed_en   = req_take && req_cmd == CMD_FEED;
   assign csr_ready = 1'b1;

   utfh_decoder u_decoder (
      .clock     (clock),
      .reset     (reset),
      .feed_en   (feed_en),
      .text_byte (req_text_byte),
      .cp_evt    (cp_evt)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= RANGE_FIRST_RESET;
         last_ff  <= RANGE_LAST_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_RANGE_FIRST: first_ff <= csr_wdata;
            CSR_RANGE_LAST:  last_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
      end else if (clear_ff) begin
         clear_addr_ff <= clear_addr_ff + ADDR_W'(1);
         if (clear_addr_ff == LAST_ADDR) begin
            clear_ff <= 1'b0;
         end
      end
   end

   // The bin limit check also covers the clip of the range's upper end.
   assign bin_diff  = cp_evt.codepoint - first_ff;
   assign s2_inc_in = cp_evt.valid && cp_evt.codepoint >= first_ff &&
                      cp_evt.codepoint <= last_ff && {1'b0, bin_diff} < BIN_LIMIT;
   assign rd_addr   = cp_evt.valid ? bin_diff[ADDR_W-1:0] : ADDR_W'(s1_idx_ff);

   assign cur_count = fwd_hit_ff ? fwd_data_ff : ram_rd_data;
   assign new_count = (&cur_count) ? cur_count : cur_count + COUNT_WIDTH'(1);

   assign wr_en   = clear_ff || s2_inc_ff;
   assign wr_addr = clear_ff ? clear_addr_ff : s2_addr_ff;
   assign wr_data = clear_ff ? '0 : new_count;

   utfh_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (BIN_COUNT)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_rd_ff     <= 1'b0;
         s2_inc_ff    <= 1'b0;
         s2_rd_ff     <= 1'b0;
         fwd_hit_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_rd_ff   <= req_take && req_cmd == CMD_READ;
         s2_inc_ff  <= s2_inc_in;
         s2_rd_ff   <= s1_rd_ff;
         fwd_hit_ff <= s2_inc_ff && s2_addr_ff == rd_addr;
         if (s2_rd_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_idx_ff <= req_bin_index;
      end
      s2_addr_ff  <= rd_addr;
      s2_oob_ff   <= (CP_WIDTH+1)'(s1_idx_ff) >= BIN_LIMIT;
      s2_cp_ff    <= first_ff + CP_WIDTH'(s1_idx_ff);
      fwd_data_ff <= new_count;
      if (s2_rd_ff) begin
         rsp_count_ff <= s2_oob_ff ? '0 : RSP_COUNT_WIDTH'(cur_count);
         rsp_cp_ff    <= s2_cp_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_bin_count     = rsp_count_ff;
   assign rsp_bin_codepoint = rsp_cp_ff;

   a_one_read_in_flight: assert property (@(posedge clock) disable iff (reset)
      $countones({s1_rd_ff, s2_rd_ff, rsp_valid_ff}) <= 1)
      else $error("more than one read transaction in flight");

   a_fwd_after_write: assert property (@(posedge clock) disable iff (reset)
      fwd_hit_ff |-> $past(s2_inc_ff))
      else $error("forwarding hit without a preceding count update");

   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s2_rd_ff))
      else $error("result raised without a read in the last stage");

   a_clear_full_pass: assert property (@(posedge clock) disable iff (reset)
      $fell(clear_ff) |-> $past(clear_addr_ff) == LAST_ADDR)
      else $error("clearing pass ended before the last bin");

endmodule

`default_nettype wire
